// ===== src/cwa_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cwa_pkg
// Shared types and constants of the chain work accumulator: command codes,
// controller states and the command and status groups between the controller
// and the datapath.
// ----------------------------------------------------------------------------
package cwa_pkg;

	localparam int TOTAL_W = 256;
	localparam int WORD_W  = 64;
	localparam int LIMB_W  = 32;
	localparam int ADD_STEPS = TOTAL_W / WORD_W;
	localparam int MUL_STEPS = TOTAL_W / LIMB_W;
	localparam int QUOT_W    = 33;
	localparam int CNT_W     = 6;
	localparam int MANT_W    = 24;
	localparam int ZERO_W    = 10;
	localparam int REM_W     = 24;
	localparam int INV_SHIFT = 31;

	localparam logic [2:0] CMD_CLEAR = 3'd0;
	localparam logic [2:0] CMD_LOAD  = 3'd1;
	localparam logic [2:0] CMD_ADD   = 3'd2;
	localparam logic [2:0] CMD_SUB   = 3'd3;
	localparam logic [2:0] CMD_MUL   = 3'd4;
	localparam logic [2:0] CMD_TADD  = 3'd5;
	localparam logic [2:0] CMD_TSUB  = 3'd6;
	localparam logic [2:0] CMD_NOP   = 3'd7;

	// remainder start values: dividend 2^55 or 2^53 with the low quotient bits removed
	localparam logic [REM_W-1:0] REM_INIT_FMT0 = REM_W'(1) << (24 + 31 - QUOT_W);
	localparam logic [REM_W-1:0] REM_INIT_FMT1 = REM_W'(1) << (22 + 31 - QUOT_W);

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_DIV,
		S_SHIFT,
		S_ADD,
		S_MULP,
		S_MULA,
		S_FIN
	} state_t;

	typedef struct packed {
		logic capture;
		logic clear;
		logic load;
		logic add_init;
		logic add_step;
		logic mul_init;
		logic mul_prod;
		logic mul_acc;
		logic div_init;
		logic div_step;
		logic shift;
		logic set_rej;
		logic out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic mant_ok;
		logic range_ok;
	} dp_sts_t;

endpackage

// ===== src/cwa_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cwa_ctrl
// Controller of the chain work accumulator: sequences clear, load, word-wise
// add and subtract, limb-wise multiply and the serial target division, and
// owns the handshakes of both channels.
// ----------------------------------------------------------------------------
module cwa_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [2:0]             cmd,
	output logic                   out_valid,
	input  logic                   out_ready,
	input  cwa_pkg::dp_sts_t       sts,
	output cwa_pkg::dp_cmd_t       dcmd
);

	cwa_pkg::state_t               state_q;
	cwa_pkg::state_t               state_nx;
	logic [2:0]                    cmd_q;
	logic [cwa_pkg::CNT_W-1:0]     cnt_q;
	logic                          cnt_clr;
	logic                          cnt_inc;
	logic                          out_valid_q;
	logic                          accept;
	logic                          out_free;

	assign in_ready  = (state_q == cwa_pkg::S_IDLE);
	assign accept    = in_valid & in_ready;
	assign out_valid = out_valid_q;
	assign out_free  = ~out_valid_q | out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= cwa_pkg::S_IDLE;
			cmd_q       <= cwa_pkg::CMD_NOP;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (accept) begin
				cmd_q <= cmd;
			end
			if (cnt_clr) begin
				cnt_q <= '0;
			end else if (cnt_inc) begin
				cnt_q <= cnt_q + 1'b1;
			end
			out_valid_q <= dcmd.out_load | (out_valid_q & ~out_ready);
		end
	end

	// next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			cwa_pkg::S_IDLE: begin
				if (accept) state_nx = cwa_pkg::S_EXEC;
			end
			cwa_pkg::S_EXEC: begin
				unique case (cmd_q)
					cwa_pkg::CMD_ADD, cwa_pkg::CMD_SUB: state_nx = cwa_pkg::S_ADD;
					cwa_pkg::CMD_MUL: state_nx = cwa_pkg::S_MULP;
					cwa_pkg::CMD_TADD, cwa_pkg::CMD_TSUB: begin
						state_nx = sts.mant_ok ? cwa_pkg::S_DIV : cwa_pkg::S_FIN;
					end
					default: state_nx = cwa_pkg::S_FIN;
				endcase
			end
			cwa_pkg::S_DIV: begin
				if (cnt_q == cwa_pkg::CNT_W'(cwa_pkg::QUOT_W - 1)) state_nx = cwa_pkg::S_SHIFT;
			end
			cwa_pkg::S_SHIFT: begin
				state_nx = sts.range_ok ? cwa_pkg::S_ADD : cwa_pkg::S_FIN;
			end
			cwa_pkg::S_ADD: begin
				if (cnt_q == cwa_pkg::CNT_W'(cwa_pkg::ADD_STEPS - 1)) state_nx = cwa_pkg::S_FIN;
			end
			cwa_pkg::S_MULP: begin
				state_nx = cwa_pkg::S_MULA;
			end
			cwa_pkg::S_MULA: begin
				if (cnt_q == cwa_pkg::CNT_W'(cwa_pkg::MUL_STEPS - 1)) state_nx = cwa_pkg::S_FIN;
				else state_nx = cwa_pkg::S_MULP;
			end
			cwa_pkg::S_FIN: begin
				if (out_free) state_nx = cwa_pkg::S_IDLE;
			end
			default: state_nx = cwa_pkg::S_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		dcmd    = '0;
		cnt_clr = 1'b0;
		cnt_inc = 1'b0;
		unique case (state_q)
			cwa_pkg::S_IDLE: begin
				dcmd.capture = accept;
			end
			cwa_pkg::S_EXEC: begin
				cnt_clr = 1'b1;
				unique case (cmd_q)
					cwa_pkg::CMD_CLEAR: dcmd.clear = 1'b1;
					cwa_pkg::CMD_LOAD:  dcmd.load = 1'b1;
					cwa_pkg::CMD_ADD, cwa_pkg::CMD_SUB: dcmd.add_init = 1'b1;
					cwa_pkg::CMD_MUL:   dcmd.mul_init = 1'b1;
					cwa_pkg::CMD_TADD, cwa_pkg::CMD_TSUB: begin
						dcmd.div_init = sts.mant_ok;
						dcmd.set_rej  = ~sts.mant_ok;
					end
					default: ;
				endcase
			end
			cwa_pkg::S_DIV: begin
				dcmd.div_step = 1'b1;
				cnt_inc       = 1'b1;
			end
			cwa_pkg::S_SHIFT: begin
				cnt_clr       = 1'b1;
				dcmd.shift    = sts.range_ok;
				dcmd.add_init = sts.range_ok;
				dcmd.set_rej  = ~sts.range_ok;
			end
			cwa_pkg::S_ADD: begin
				dcmd.add_step = 1'b1;
				cnt_inc       = 1'b1;
			end
			cwa_pkg::S_MULP: begin
				dcmd.mul_prod = 1'b1;
			end
			cwa_pkg::S_MULA: begin
				dcmd.mul_acc = 1'b1;
				cnt_inc      = 1'b1;
			end
			cwa_pkg::S_FIN: begin
				dcmd.out_load = out_free;
			end
			default: ;
		endcase
	end

endmodule

// ===== src/cwa_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cwa_dp
// Datapath of the chain work accumulator: the 256-bit total, the operand
// register, a 64-bit adder with carry, a 32x32 multiplier, the restoring
// divider for the target inverse and the result register.
// ----------------------------------------------------------------------------
module cwa_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  cwa_pkg::dp_cmd_t              dcmd,
	output cwa_pkg::dp_sts_t              sts,
	input  logic [2:0]                    cmd,
	input  logic                          target_format,
	input  logic [cwa_pkg::ZERO_W-1:0]    zero_count,
	input  logic [cwa_pkg::MANT_W-1:0]    mantissa,
	input  logic [cwa_pkg::LIMB_W-1:0]    factor,
	input  logic [cwa_pkg::TOTAL_W-1:0]   operand,
	output logic [cwa_pkg::TOTAL_W-1:0]   total,
	output logic                          rejected
);

	localparam int SH_W = cwa_pkg::TOTAL_W + 2 * cwa_pkg::WORD_W - 1;

	logic [cwa_pkg::TOTAL_W-1:0]   total_q;
	logic [cwa_pkg::TOTAL_W-1:0]   b_q;
	logic [cwa_pkg::TOTAL_W-1:0]   total_out_q;
	logic                          rej_out_q;
	logic                          rej_q;
	logic                          sub_q;
	logic                          fmt_q;
	logic [cwa_pkg::ZERO_W-1:0]    zeros_q;
	logic [cwa_pkg::MANT_W-1:0]    mant_q;
	logic [cwa_pkg::LIMB_W-1:0]    factor_q;
	logic                          carry_q;
	logic [cwa_pkg::LIMB_W-1:0]    mcarry_q;
	logic [2*cwa_pkg::LIMB_W-1:0]  prod_q;
	logic [cwa_pkg::REM_W-1:0]     rem_q;
	logic [cwa_pkg::QUOT_W-1:0]    quot_q;

	logic [cwa_pkg::WORD_W:0]      sum;
	logic [cwa_pkg::WORD_W-1:0]    addend;
	logic [2*cwa_pkg::LIMB_W-1:0]  macc;
	logic [cwa_pkg::REM_W:0]       rem_sh;
	logic [cwa_pkg::REM_W:0]       rem_diff;
	logic                          rem_ge;
	logic [cwa_pkg::WORD_W-1:0]    inv_ext;
	logic [SH_W-1:0]               work_sh;

	assign addend = sub_q ? ~b_q[cwa_pkg::WORD_W-1:0] : b_q[cwa_pkg::WORD_W-1:0];
	assign sum    = {1'b0, total_q[cwa_pkg::WORD_W-1:0]} + {1'b0, addend}
	              + {{cwa_pkg::WORD_W{1'b0}}, carry_q};
	assign macc   = prod_q + {{cwa_pkg::LIMB_W{1'b0}}, mcarry_q};

	assign rem_sh   = {rem_q, 1'b0};
	assign rem_diff = rem_sh - {1'b0, mant_q};
	assign rem_ge   = ~rem_diff[cwa_pkg::REM_W];

	// inverse placed with bit 0 at zero_count-31
	assign inv_ext = {{(cwa_pkg::WORD_W - cwa_pkg::QUOT_W){1'b0}}, quot_q};
	assign work_sh = {{(SH_W - cwa_pkg::WORD_W){1'b0}}, inv_ext} << zeros_q[7:0];

	assign sts.mant_ok  = fmt_q ? (mant_q[21] & ~mant_q[23] & ~mant_q[22]) : mant_q[23];
	assign sts.range_ok = (zeros_q[9:8] == 2'b00) & ~(quot_q[32] & (zeros_q[7:0] == 8'hff));

	assign total    = total_out_q;
	assign rejected = rej_out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
		end else begin
			priority if (dcmd.clear) begin
				total_q <= '0;
			end else if (dcmd.load) begin
				total_q <= b_q;
			end else if (dcmd.add_step) begin
				total_q <= {sum[cwa_pkg::WORD_W-1:0], total_q[cwa_pkg::TOTAL_W-1:cwa_pkg::WORD_W]};
			end else if (dcmd.mul_acc) begin
				total_q <= {macc[cwa_pkg::LIMB_W-1:0], total_q[cwa_pkg::TOTAL_W-1:cwa_pkg::LIMB_W]};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rej_q <= 1'b0;
		end else begin
			if (dcmd.capture) rej_q <= 1'b0;
			else if (dcmd.set_rej) rej_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (dcmd.capture) begin
			b_q      <= operand;
			sub_q    <= (cmd == cwa_pkg::CMD_SUB) | (cmd == cwa_pkg::CMD_TSUB);
			fmt_q    <= target_format;
			zeros_q  <= zero_count;
			mant_q   <= mantissa;
			factor_q <= factor;
		end else if (dcmd.shift) begin
			b_q <= work_sh[cwa_pkg::TOTAL_W+cwa_pkg::INV_SHIFT-1:cwa_pkg::INV_SHIFT];
		end else if (dcmd.add_step) begin
			b_q <= {{cwa_pkg::WORD_W{1'b0}}, b_q[cwa_pkg::TOTAL_W-1:cwa_pkg::WORD_W]};
		end
		if (dcmd.add_init) carry_q <= sub_q;
		else if (dcmd.add_step) carry_q <= sum[cwa_pkg::WORD_W];
		if (dcmd.mul_init) mcarry_q <= '0;
		else if (dcmd.mul_acc) mcarry_q <= macc[2*cwa_pkg::LIMB_W-1:cwa_pkg::LIMB_W];
		if (dcmd.mul_prod) prod_q <= total_q[cwa_pkg::LIMB_W-1:0] * factor_q;
		if (dcmd.div_init) begin
			rem_q  <= fmt_q ? cwa_pkg::REM_INIT_FMT1 : cwa_pkg::REM_INIT_FMT0;
			quot_q <= '0;
		end else if (dcmd.div_step) begin
			rem_q  <= rem_ge ? rem_diff[cwa_pkg::REM_W-1:0] : rem_sh[cwa_pkg::REM_W-1:0];
			quot_q <= {quot_q[cwa_pkg::QUOT_W-2:0], rem_ge};
		end
		if (dcmd.out_load) begin
			total_out_q <= total_q;
			rej_out_q   <= rej_q;
		end
	end

endmodule

// ===== src/chain_work_accumulator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chain_work_accumulator
// 256-bit chain work total with clear, load, add, subtract, multiply and
// add or subtract of the work of a compact target.
//
// Input channel in_valid/in_ready carries one command word; output channel
// out_valid/out_ready returns one word per command: the new total and the
// reject flag. A new command is taken only when the previous one has been
// worked through; a finished result waits in the output register, so the
// next command is taken while the receiver stalls.
// Per command, from accept to result register: clear, load and unused
// codes go straight through; add and subtract run word-wise on the 64-bit
// adder; multiply forms and adds one product per 32-bit limb through one
// 32x32 multiplier; target work runs the 33-step restoring division of
// 2^55 or 2^53 by the mantissa, then a 64-bit word add per cycle. A target
// rejected for its mantissa skips both, one for its position the add.
// Reset clears the total to zero and empties the output register.
// When the receiver stalls, the block holds the next result until the
// output register is free and takes no further command meanwhile.
// ----------------------------------------------------------------------------
module chain_work_accumulator (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	input  logic [2:0]   cmd,
	input  logic         target_format,
	input  logic [9:0]   zero_count,
	input  logic [23:0]  mantissa,
	input  logic [31:0]  factor,
	input  logic [63:0]  operand_word0,
	input  logic [63:0]  operand_word1,
	input  logic [63:0]  operand_word2,
	input  logic [63:0]  operand_word3,
	output logic         out_valid,
	input  logic         out_ready,
	output logic [63:0]  total_word0,
	output logic [63:0]  total_word1,
	output logic [63:0]  total_word2,
	output logic [63:0]  total_word3,
	output logic         rejected
);

	cwa_pkg::dp_cmd_t              dcmd;
	cwa_pkg::dp_sts_t              sts;
	logic [cwa_pkg::TOTAL_W-1:0]   total;

	cwa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.cmd       (cmd),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.dcmd      (dcmd)
	);

	cwa_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.dcmd          (dcmd),
		.sts           (sts),
		.cmd           (cmd),
		.target_format (target_format),
		.zero_count    (zero_count),
		.mantissa      (mantissa),
		.factor        (factor),
		.operand       ({operand_word3, operand_word2, operand_word1, operand_word0}),
		.total         (total),
		.rejected      (rejected)
	);

	assign total_word0 = total[63:0];
	assign total_word1 = total[127:64];
	assign total_word2 = total[191:128];
	assign total_word3 = total[255:192];

endmodule

// ===== bench/chain_work_accumulator_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chain_work_accumulator_test
// Self-checking bench for the chain work accumulator. A directed opening
// covers every command, the wrap-around cases and the target boundaries
// (unnormalized mantissa, work at the top of 256 bits, a quotient of
// exactly 2^32). Random commands follow in phases with different sender
// gaps and receiver stalls. A scoreboard object predicts each new total and
// reject flag and checks every returned word in order.
// ----------------------------------------------------------------------------
module chain_work_accumulator_test;

	localparam logic FMT_24BIT = 1'b0;
	localparam logic FMT_22BIT = 1'b1;
	localparam int CYCLE_LIMIT = 400000;
	localparam int HOLD_CYCLES = 300;
	localparam int PHASE_WORDS = 132;

	class work_ledger;
		logic [255:0] work_total;
		logic [255:0] expected_totals[$];
		logic         expected_rejects[$];
		int           errors;

		function new();
			work_total = '0;
			errors = 0;
		endfunction

		// floor(invbits * 2^(zeros - 31)), or 0 when the target is refused
		function logic target_work(input logic f, input logic [9:0] z,
				input logic [23:0] m, output logic [255:0] w);
			logic [63:0]  invbits;
			logic [511:0] placed;
			w = '0;
			if (f == FMT_24BIT) begin
				if (!m[23])
					return 1'b0;
				invbits = (64'd1 << 55) / {40'd0, m};
			end else begin
				if (!m[21] || m[23:22] != 2'b00)
					return 1'b0;
				invbits = (64'd1 << 53) / {40'd0, m};
			end
			if ({1'b0, z} + ((invbits == (64'd1 << 32)) ? 11'd1 : 11'd0) > 11'd255)
				return 1'b0;
			placed = {448'd0, invbits} << z;
			w = placed[286:31];
			return 1'b1;
		endfunction

		function void take_command(input logic [2:0] c, input logic f,
				input logic [9:0] z, input logic [23:0] m, input logic [31:0] k,
				input logic [255:0] op);
			logic [255:0] w;
			logic         rej;
			rej = 1'b0;
			case (c)
				cwa_pkg::CMD_CLEAR: work_total = '0;
				cwa_pkg::CMD_LOAD:  work_total = op;
				cwa_pkg::CMD_ADD:   work_total = work_total + op;
				cwa_pkg::CMD_SUB:   work_total = work_total - op;
				cwa_pkg::CMD_MUL:   work_total = work_total * {224'd0, k};
				cwa_pkg::CMD_TADD, cwa_pkg::CMD_TSUB: begin
					if (target_work(f, z, m, w)) begin
						if (c == cwa_pkg::CMD_TADD)
							work_total = work_total + w;
						else
							work_total = work_total - w;
					end else begin
						rej = 1'b1;
					end
				end
				default: ;
			endcase
			expected_totals.push_back(work_total);
			expected_rejects.push_back(rej);
		endfunction

		function void check_total(input logic [255:0] got, input logic got_rej);
			logic [255:0] want;
			logic         want_rej;
			int           i;
			if (expected_totals.size() == 0) begin
				$display("%0t: unexpected word, total %h rejected %b", $time, got, got_rej);
				errors++;
				return;
			end
			want = expected_totals.pop_front();
			want_rej = expected_rejects.pop_front();
			for (i = 0; i < 4; i++) begin
				if (got[i*64 +: 64] !== want[i*64 +: 64]) begin
					$display("%0t: total_word%0d expected %h got %h", $time, i,
						want[i*64 +: 64], got[i*64 +: 64]);
					errors++;
				end
			end
			if (got_rej !== want_rej) begin
				$display("%0t: rejected expected %b got %b", $time, want_rej, got_rej);
				errors++;
			end
		endfunction

		function int pending();
			return expected_totals.size();
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [2:0]  cmd = cwa_pkg::CMD_CLEAR;
	logic        target_format = FMT_24BIT;
	logic [9:0]  zero_count = '0;
	logic [23:0] mantissa = '0;
	logic [31:0] factor = '0;
	logic [63:0] operand_word0 = '0;
	logic [63:0] operand_word1 = '0;
	logic [63:0] operand_word2 = '0;
	logic [63:0] operand_word3 = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [63:0] total_word0;
	logic [63:0] total_word1;
	logic [63:0] total_word2;
	logic [63:0] total_word3;
	logic        rejected;

	work_ledger ledger;
	int         send_idle_pct = 0;
	int         recv_stall_pct = 0;
	int         hold_reqs = 0;
	int         hold_seen = 0;
	int         hold_left = 0;
	int         cycle_count = 0;

	chain_work_accumulator i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.cmd           (cmd),
		.target_format (target_format),
		.zero_count    (zero_count),
		.mantissa      (mantissa),
		.factor        (factor),
		.operand_word0 (operand_word0),
		.operand_word1 (operand_word1),
		.operand_word2 (operand_word2),
		.operand_word3 (operand_word3),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.total_word0   (total_word0),
		.total_word1   (total_word1),
		.total_word2   (total_word2),
		.total_word3   (total_word3),
		.rejected      (rejected)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// receiver: random stalls, plus a long hold-off on request
	always @(posedge clk) begin
		if (hold_seen != hold_reqs) begin
			hold_seen <= hold_reqs;
			hold_left <= HOLD_CYCLES;
			out_ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				ledger.take_command(cmd, target_format, zero_count, mantissa, factor,
					{operand_word3, operand_word2, operand_word1, operand_word0});
			if (out_valid && out_ready)
				ledger.check_total({total_word3, total_word2, total_word1, total_word0},
					rejected);
		end
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("chain_work_accumulator_test NOT OK");
		$finish;
	end

	function automatic logic [255:0] rand_operand();
		logic [255:0] op;
		int           i;
		for (i = 0; i < 4; i++) begin
			case ($urandom_range(15))
				0:       op[i*64 +: 64] = '0;
				1:       op[i*64 +: 64] = '1;
				default: op[i*64 +: 64] = {$urandom, $urandom};
			endcase
		end
		return op;
	endfunction

	task automatic drive_word(input logic [2:0] c, input logic f, input logic [9:0] z,
			input logic [23:0] m, input logic [31:0] k, input logic [255:0] op);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		cmd <= c;
		target_format <= f;
		zero_count <= z;
		mantissa <= m;
		factor <= k;
		operand_word0 <= op[63:0];
		operand_word1 <= op[127:64];
		operand_word2 <= op[191:128];
		operand_word3 <= op[255:192];
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	task automatic drive_target(input logic [2:0] c, input logic f, input logic [9:0] z,
			input logic [23:0] m);
		drive_word(c, f, z, m, $urandom, rand_operand());
	endtask

	task automatic random_word();
		logic [2:0]  c;
		logic        f;
		logic [9:0]  z;
		logic [23:0] m;
		logic [31:0] k;
		int          pick;
		pick = $urandom_range(99);
		if (pick < 4)
			c = cwa_pkg::CMD_CLEAR;
		else if (pick < 14)
			c = cwa_pkg::CMD_LOAD;
		else if (pick < 26)
			c = cwa_pkg::CMD_ADD;
		else if (pick < 38)
			c = cwa_pkg::CMD_SUB;
		else if (pick < 52)
			c = cwa_pkg::CMD_MUL;
		else if (pick < 75)
			c = cwa_pkg::CMD_TADD;
		else if (pick < 97)
			c = cwa_pkg::CMD_TSUB;
		else
			c = cwa_pkg::CMD_NOP;
		f = 1'($urandom_range(1));
		pick = $urandom_range(99);
		if (pick < 8)
			m = (f == FMT_24BIT) ? 24'h800000 : 24'h200000;
		else if (pick < 75)
			m = (f == FMT_24BIT) ? {1'b1, 23'($urandom)} : {3'b001, 21'($urandom)};
		else
			m = 24'($urandom);
		pick = $urandom_range(99);
		if (pick < 70)
			z = 10'($urandom_range(255));
		else if (pick < 85)
			z = 10'($urandom_range(256, 250));
		else
			z = 10'($urandom_range(1023));
		case ($urandom_range(9))
			0:       k = '0;
			1:       k = 32'd1;
			2:       k = '1;
			default: k = $urandom;
		endcase
		drive_word(c, f, z, m, k, rand_operand());
	endtask

	task automatic wait_drained();
		@(posedge clk);
		while (ledger.pending() != 0)
			@(posedge clk);
	endtask

	initial begin
		int p;
		int send_pcts[4];
		int recv_pcts[4];
		send_pcts = '{0, 88, 0, 17};
		recv_pcts = '{0, 0, 88, 17};
		ledger = new();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// wrap-around and plain commands
		drive_word(cwa_pkg::CMD_CLEAR, FMT_22BIT, '1, '1, '1, '1);
		drive_word(cwa_pkg::CMD_SUB, FMT_24BIT, '0, '0, '0, 256'd1);
		drive_word(cwa_pkg::CMD_ADD, FMT_24BIT, '0, '0, '0, '1);
		drive_word(cwa_pkg::CMD_LOAD, FMT_24BIT, '0, '0, '0, '1);
		drive_word(cwa_pkg::CMD_MUL, FMT_24BIT, '0, '0, '1, '0);
		drive_word(cwa_pkg::CMD_MUL, FMT_24BIT, '0, '0, '0, '1);
		drive_word(cwa_pkg::CMD_LOAD, FMT_24BIT, '0, '0, '0, rand_operand());
		drive_word(cwa_pkg::CMD_MUL, FMT_24BIT, '0, '0, 32'd1, '0);
		drive_word(cwa_pkg::CMD_ADD, FMT_24BIT, '0, '0, '0, rand_operand());
		drive_word(cwa_pkg::CMD_NOP, FMT_22BIT, '1, '1, '1, '1);
		// target boundaries
		drive_target(cwa_pkg::CMD_TADD, FMT_24BIT, 10'd0, 24'h800000);
		drive_target(cwa_pkg::CMD_TADD, FMT_24BIT, 10'd0, 24'hffffff);
		drive_target(cwa_pkg::CMD_TADD, FMT_24BIT, 10'd254, 24'h800000);
		drive_target(cwa_pkg::CMD_TADD, FMT_24BIT, 10'd255, 24'h800000);
		drive_target(cwa_pkg::CMD_TSUB, FMT_24BIT, 10'd255, 24'hffffff);
		drive_target(cwa_pkg::CMD_TADD, FMT_24BIT, 10'd256, 24'hc00000);
		drive_target(cwa_pkg::CMD_TADD, FMT_24BIT, 10'd1023, 24'hffffff);
		drive_target(cwa_pkg::CMD_TADD, FMT_24BIT, 10'd40, 24'h7fffff);
		drive_target(cwa_pkg::CMD_TSUB, FMT_22BIT, 10'd30, 24'h200000);
		drive_target(cwa_pkg::CMD_TADD, FMT_22BIT, 10'd31, 24'h3fffff);
		drive_target(cwa_pkg::CMD_TADD, FMT_22BIT, 10'd100, 24'h400000);
		drive_target(cwa_pkg::CMD_TADD, FMT_22BIT, 10'd100, 24'h1fffff);
		drive_target(cwa_pkg::CMD_TADD, FMT_22BIT, 10'd100, 24'ha00000);
		drive_target(cwa_pkg::CMD_TSUB, FMT_22BIT, 10'd254, 24'h200000);
		drive_target(cwa_pkg::CMD_TSUB, FMT_22BIT, 10'd255, 24'h200000);

		for (p = 0; p < 4; p++) begin
			in_valid <= 1'b0;
			wait_drained();
			send_idle_pct = send_pcts[p];
			recv_stall_pct <= recv_pcts[p];
			if (p == 0)
				hold_reqs <= hold_reqs + 1;
			repeat (PHASE_WORDS) random_word();
		end
		in_valid <= 1'b0;
		recv_stall_pct <= 0;
		wait_drained();
		repeat (60) @(posedge clk);

		if (ledger.errors == 0 && ledger.pending() == 0)
			$display("chain_work_accumulator_test OK");
		else
			$display("chain_work_accumulator_test NOT OK");
		$finish;
	end

endmodule
